/* sv/platform_interrupt_controller_macros.svh */
// Assertion macros shared by the interrupt controller RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef PLATFORM_INTERRUPT_CONTROLLER_MACROS_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PIC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pic_pkg.sv */
// Package for the platform interrupt controller: sizes, codes and the
// structs passed between the sequencer, the priority file and the scan unit.
`timescale 1ns / 1ps

package pic_pkg;

    localparam int NUM_SOURCES = 31;
    localparam int PRIO_W      = 3;
    localparam int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int ID_W        = $clog2(NUM_SOURCES + 1);
    localparam int WORD_W      = 32;

    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_READ  = 2'd1,
        FN_WRITE = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        SEL_PRIO    = 3'd0,
        SEL_THRESH  = 3'd1,
        SEL_ENABLE  = 3'd2,
        SEL_PENDING = 3'd3,
        SEL_CLAIM   = 3'd4
    } sel_t;

    typedef enum logic [1:0] {
        FLT_NONE  = 2'd0,
        FLT_LOAD  = 2'd1,
        FLT_STORE = 2'd2
    } fault_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [PRIO_W-1:0] data;
    } prio_wr_t;

    typedef struct packed {
        logic              start;
        logic [PRIO_W-1:0] threshold;
    } scan_cmd_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [ID_W-1:0] best_id;
    } scan_stat_t;

endpackage

/* sv/pic_prio_regs.sv */
// Per-source priority register file: one write port, one read port.
// Depends on pic_pkg.
`timescale 1ns / 1ps

module pic_prio_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pic_pkg::prio_wr_t         wr,
    input  logic [pic_pkg::IDX_W-1:0] rd_addr,
    output logic [pic_pkg::PRIO_W-1:0] rd_data
);
    import pic_pkg::*;

    logic [PRIO_W-1:0] prio_reg [NUM_SOURCES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                prio_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            prio_reg[wr.addr] <= wr.data;
        end
    end

    // addresses past the last source read as zero
    assign rd_data = (rd_addr < IDX_W'(NUM_SOURCES)) ? prio_reg[rd_addr] : '0;

endmodule

/* sv/pic_scan.sv */
// Claim scan unit: one shared priority compare stepped over all sources,
// one source per cycle. Depends on pic_pkg.
`timescale 1ns / 1ps

module pic_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pic_pkg::scan_cmd_t          cmd,
    input  logic [pic_pkg::WORD_W-1:0]  pending,
    input  logic [pic_pkg::WORD_W-1:0]  enable,
    input  logic [pic_pkg::PRIO_W-1:0]  prio_rd,
    output logic [pic_pkg::IDX_W-1:0]   addr,
    output pic_pkg::scan_stat_t         stat
);
    import pic_pkg::*;

    logic [IDX_W-1:0]       cnt_reg,  cnt_next;
    logic [PRIO_W-1:0]      top_reg,  top_next;
    logic [ID_W-1:0]        id_reg,   id_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [NUM_SOURCES-1:0] cand;
    logic                   hit;
    logic                   last;

    // source k is ID k+1
    assign cand = pending[NUM_SOURCES:1] & enable[NUM_SOURCES:1];
    assign hit  = cand[cnt_reg] && (prio_rd > top_reg);
    assign last = (cnt_reg == IDX_W'(NUM_SOURCES - 1));

    always_comb
    begin
        cnt_next  = cnt_reg;
        top_next  = top_reg;
        id_next   = id_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            cnt_next  = '0;
            top_next  = cmd.threshold;
            id_next   = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                top_next = prio_rd;
                id_next  = ID_W'(cnt_reg) + ID_W'(1);
            end
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            top_reg  <= '0;
            id_reg   <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            top_reg  <= top_next;
            id_reg   <= id_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign addr         = cnt_reg;
    assign stat.busy    = busy_reg;
    assign stat.done    = done_reg;
    assign stat.best_id = id_reg;

endmodule

/* sv/platform_interrupt_controller.sv */
// Platform interrupt controller top level: command sequencer, threshold,
// enable and pending registers, result register. Depends on pic_pkg,
// pic_prio_regs, pic_scan and platform_interrupt_controller_macros.svh.
`timescale 1ns / 1ps
//
// Usage:
//   Slave channel (s_*) takes one command transaction: a tick that loads the
//   raised source vector into the pending mask, a register read or a
//   register write. Master channel (m_*) returns exactly one result
//   transaction per command: read data, fault code and the external
//   interrupt flag (set only on a tick when some ID is claimable).
//   Ticks and claim reads run the claim scan: one source per cycle through a
//   single priority comparator over all NUM_SOURCES (31) sources, and the
//   result then goes to the output register. All other commands give their
//   result in the cycle after acceptance.
//   One command is in flight at a time: s_tready is low while a scan runs and
//   while a result waits in the output register. If the receiver stalls, the
//   result holds and no new command is taken until it is delivered.
//   Reset clears all priorities, the masks and the threshold; no result is
//   pending after reset.
//
module platform_interrupt_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] prio_index, [37:6] write_data, [69:38] source_pending, rest zero
    input  logic [71:0] s_tdata,
    // [1:0] func, [4:2] reg_select
    input  logic [4:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] read_data, [32] ext_irq, rest zero
    output logic [39:0] m_tdata,
    // [1:0] fault
    output logic [1:0]  m_tuser
);
    import pic_pkg::*;

    `include "platform_interrupt_controller_macros.svh"

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t              state_reg,  state_next;
    logic [WORD_W-1:0]   pend_reg,   pend_next;
    logic [WORD_W-1:0]   enab_reg,   enab_next;
    logic [PRIO_W-1:0]   thr_reg,    thr_next;
    logic                tick_reg,   tick_next;
    logic                ovld_reg,   ovld_next;
    logic [WORD_W-1:0]   rd_reg,     rd_next;
    fault_t              flt_reg,    flt_next;
    logic                irq_reg,    irq_next;

    logic [5:0]          in_idx;
    logic [WORD_W-1:0]   in_wdata;
    logic [WORD_W-1:0]   in_src;
    func_t               in_func;
    sel_t                in_sel;
    logic                accept;
    logic                idx_ok;
    logic                needs_scan;

    prio_wr_t            prio_wr;
    logic [IDX_W-1:0]    prio_addr;
    logic [PRIO_W-1:0]   prio_rd;
    logic [IDX_W-1:0]    scan_addr;
    scan_cmd_t           scan_cmd;
    scan_stat_t          scan_stat;

    assign in_idx   = s_tdata[5:0];
    assign in_wdata = s_tdata[37:6];
    assign in_src   = s_tdata[69:38];
    assign in_func  = func_t'(s_tuser[1:0]);
    assign in_sel   = sel_t'(s_tuser[4:2]);

    assign s_tready = (state_reg == ST_IDLE) && !ovld_reg;
    assign accept   = s_tvalid && s_tready;
    assign idx_ok   = (in_idx < 6'(NUM_SOURCES));

    assign needs_scan = (in_func == FN_TICK) ||
                        ((in_func == FN_READ) && (in_sel == SEL_CLAIM));

    assign prio_wr.en   = accept && (in_func == FN_WRITE) && (in_sel == SEL_PRIO) && idx_ok;
    assign prio_wr.addr = in_idx[IDX_W-1:0];
    assign prio_wr.data = in_wdata[PRIO_W-1:0];

    assign prio_addr = scan_stat.busy ? scan_addr : in_idx[IDX_W-1:0];

    assign scan_cmd.start     = accept && needs_scan;
    assign scan_cmd.threshold = thr_reg;

    pic_prio_regs u_prio (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (prio_wr),
        .rd_addr (prio_addr),
        .rd_data (prio_rd)
    );

    pic_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (scan_cmd),
        .pending (pend_reg),
        .enable  (enab_reg),
        .prio_rd (prio_rd),
        .addr    (scan_addr),
        .stat    (scan_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        enab_next  = enab_reg;
        thr_next   = thr_reg;
        tick_next  = tick_reg;
        ovld_next  = ovld_reg;
        rd_next    = rd_reg;
        flt_next   = flt_reg;
        irq_next   = irq_reg;

        if (ovld_reg && m_tready)
        begin
            ovld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_next  = '0;
                    flt_next = FLT_NONE;
                    irq_next = 1'b0;
                    if (needs_scan)
                    begin
                        state_next = ST_SCAN;
                        tick_next  = (in_func == FN_TICK);
                        if (in_func == FN_TICK)
                        begin
                            pend_next = in_src;
                        end
                    end
                    else
                    begin
                        ovld_next = 1'b1;
                        case (in_func)
                            FN_READ:
                            begin
                                case (in_sel)
                                    SEL_PRIO:
                                    begin
                                        if (idx_ok)
                                        begin
                                            rd_next = WORD_W'(prio_rd);
                                        end
                                        else
                                        begin
                                            flt_next = FLT_LOAD;
                                        end
                                    end
                                    SEL_THRESH:  rd_next  = WORD_W'(thr_reg);
                                    SEL_ENABLE:  rd_next  = enab_reg;
                                    SEL_PENDING: rd_next  = pend_reg;
                                    default:     flt_next = FLT_LOAD;
                                endcase
                            end
                            FN_WRITE:
                            begin
                                case (in_sel)
                                    SEL_PRIO:
                                    begin
                                        if (!idx_ok)
                                        begin
                                            flt_next = FLT_STORE;
                                        end
                                    end
                                    SEL_THRESH: thr_next  = in_wdata[PRIO_W-1:0];
                                    SEL_ENABLE: enab_next = {in_wdata[WORD_W-1:1], 1'b0};
                                    SEL_CLAIM:
                                    begin
                                        // completion of IDs 1..31 only
                                        if ((in_wdata[WORD_W-1:5] == '0) && (in_wdata[4:0] != '0))
                                        begin
                                            pend_next = pend_reg & ~(WORD_W'(1) << in_wdata[4:0]);
                                        end
                                    end
                                    default: flt_next = FLT_STORE;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = ST_IDLE;
                    ovld_next  = 1'b1;
                    if (tick_reg)
                    begin
                        irq_next = (scan_stat.best_id != '0);
                    end
                    else
                    begin
                        rd_next = WORD_W'(scan_stat.best_id);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            enab_reg  <= '0;
            thr_reg   <= '0;
            tick_reg  <= 1'b0;
            ovld_reg  <= 1'b0;
            rd_reg    <= '0;
            flt_reg   <= FLT_NONE;
            irq_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            enab_reg  <= enab_next;
            thr_reg   <= thr_next;
            tick_reg  <= tick_next;
            ovld_reg  <= ovld_next;
            rd_reg    <= rd_next;
            flt_reg   <= flt_next;
            irq_reg   <= irq_next;
        end
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = {7'b0, irq_reg, rd_reg};
    assign m_tuser  = flt_reg;

    `PIC_ASSERT_NOW(a_ready_excl, s_tready, !m_tvalid && !scan_stat.busy,
        "command taken while a result or scan is outstanding")
    `PIC_ASSERT_NOW(a_done_in_scan, scan_stat.done, state_reg == ST_SCAN,
        "scan finished outside of scan state")
    `PIC_ASSERT_NEXT(a_direct_result, accept && !needs_scan, m_tvalid,
        "direct command did not produce a result next cycle")
    `PIC_ASSERT_NEXT(a_scan_start, scan_cmd.start, scan_stat.busy && !m_tvalid,
        "scan did not start after a tick or claim read")
    `PIC_ASSERT_NOW(a_fault_clean, m_tvalid && (m_tuser != FLT_NONE),
        (m_tdata[31:0] == '0) && !m_tdata[32],
        "faulted result carries data or interrupt")

endmodule
